// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- rtl/mndt_pkg.sv -----
`timescale 1ns / 1ps

package mndt_pkg;

  localparam int NOTE_SLOTS = 64;
  localparam int SLOT_W     = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;

  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;

  // two-entry queues: one pointer bit, count up to two
  localparam int Q_DEPTH = 2;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PRESS,
    OP_RELEASE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic [31:0] time_stamp;
    logic [1:0]  hand;
  } cmd_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [6:0]  event_key;
    logic        is_release;
    logic        table_full;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRESS,
    BK_REL_SCAN,
    BK_REL_DRAIN,
    BK_REL_DONE
  } back_state_t;

endpackage

// ----- rtl/midi_note_duration_tracker.sv -----
`timescale 1ns / 1ps
// Channel    Handshake               Words
// input      push / full             kind, status, key, velocity, time_stamp, hand
// result     empty / pop             start_time, end_time, event_key, is_release, table_full
//
// Sequence: an accepted word waits in the command queue. A clear is done in the
// sequencer at dispatch, a press is dispatched and then scans for a free slot, one
// slot a cycle; a release reads key/start memory for every slot, then passes the
// compare stage, a drain state and a commit state. Ignored statuses never leave
// the front end.
// Reset: rst, synchronous, clears queues, sequencer and the slot valid flags at once.
// Stalls: a press or release starts only when the result queue has room; the
// command queue keeps taking words while the sequencer is busy.

module midi_note_duration_tracker
  import mndt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [3:0]  status,
  input  logic [6:0]  key,
  input  logic [6:0]  velocity,
  input  logic [31:0] time_stamp,
  input  logic [1:0]  hand,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [31:0] start_time,
  output logic [31:0] end_time,
  output logic [6:0]  event_key,
  output logic        is_release,
  output logic        table_full
);

  // front end to sequencer
  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;

  // sequencer to result queue
  logic    out_space;
  logic    out_push;
  result_t out_word;
  result_t res;

  // front end: classifies each word and queues clear / press / release
  mndt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .status     (status),
    .key        (key),
    .velocity   (velocity),
    .time_stamp (time_stamp),
    .hand       (hand),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // back end: slot table and scan sequencer
  mndt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_space (out_space),
    .out_push  (out_push),
    .out_word  (out_word)
  );

  // result queue decouples the sequencer from the consumer
  mndt_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .in_push  (out_push),
    .in_word  (out_word),
    .space    (out_space),
    .pop      (pop),
    .empty    (empty),
    .out_word (res)
  );

  assign start_time = res.start_time;
  assign end_time   = res.end_time;
  assign event_key  = res.event_key;
  assign is_release = res.is_release;
  assign table_full = res.table_full;

endmodule

// ----- rtl/mndt_front.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mndt_front
  import mndt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [3:0]  status,
  input  logic [6:0]  key,
  input  logic [6:0]  velocity,
  input  logic [31:0] time_stamp,
  input  logic [1:0]  hand,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t               cmd_mem [Q_DEPTH];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [Q_CNT_W-1:0] count;

  op_t  op;
  logic keep;
  logic wr_en;

  // classify: clear, press, release; anything else is dropped here
  always_comb begin
    op   = OP_CLEAR;
    keep = 1'b1;
    if (kind) begin
      op = OP_CLEAR;
    end else if (status == ST_NOTE_ON && velocity != 7'd0) begin
      op = OP_PRESS;
    end else if (status == ST_NOTE_ON || status == ST_NOTE_OFF) begin
      op = OP_RELEASE;
    end else begin
      keep = 1'b0;
    end
  end

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign wr_en     = push && !full && keep;
  assign cmd_valid = (count != '0);
  assign cmd       = cmd_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cmd_mem[wr_ptr] <= '{op: op, key: key, velocity: velocity,
                           time_stamp: time_stamp, hand: hand};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!wr_en && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_PROP(a_pop_needs_word, clk, rst, cmd_pop |-> cmd_valid)

endmodule

// ----- rtl/mndt_out_queue.sv -----
`timescale 1ns / 1ps

module mndt_out_queue
  import mndt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_push,
  input  result_t in_word,
  output logic    space,
  input  logic    pop,
  output logic    empty,
  output result_t out_word
);

  result_t            mem [Q_DEPTH];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               rd_en;

  assign space    = (count != Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign rd_en    = pop && !empty;
  assign out_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_push) begin
      mem[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (in_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (in_push && !rd_en) begin
        count <= count + 1'b1;
      end else if (!in_push && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mndt_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mndt_back
  import mndt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  input  logic    out_space,
  output logic    out_push,
  output result_t out_word
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NOTE_SLOTS - 1);

  back_state_t state, state_next;
  logic [SLOT_W-1:0] scan_idx, scan_idx_next;
  cmd_t              cmd_q;

  logic [NOTE_SLOTS-1:0] used;
  logic [NOTE_SLOTS-1:0] committed;

  // per-slot payload memories
  logic [6:0]  key_mem    [NOTE_SLOTS];
  logic [31:0] start_mem  [NOTE_SLOTS];
  logic [8:0]  detail_mem [NOTE_SLOTS];
  logic [31:0] len_mem    [NOTE_SLOTS];

  logic [6:0]  key_rd;
  logic [31:0] start_rd;

  // compare stage of the release scan
  logic              cmp_vld;
  logic [SLOT_W-1:0] cmp_idx;
  logic              hit;
  logic [31:0]       gap;

  logic              found;
  logic [SLOT_W-1:0] best_idx;
  logic [31:0]       best_dist;
  logic [31:0]       best_start;

  logic alloc, commit, clear_all, issue, start_rel;
  logic              len_we;
  logic [SLOT_W-1:0] len_addr;
  logic [31:0]       len_data;

  assign gap = cmd_q.time_stamp - start_rd;
  assign hit  = used[cmp_idx] && (key_rd == cmd_q.key) && (start_rd < cmd_q.time_stamp);

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    cmd_pop       = 1'b0;
    out_push      = 1'b0;
    out_word      = '0;
    alloc         = 1'b0;
    commit        = 1'b0;
    clear_all     = 1'b0;
    issue         = 1'b0;
    start_rel     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && (cmd.op == OP_CLEAR || out_space)) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_CLEAR: begin
              clear_all = 1'b1;
            end
            OP_PRESS: begin
              state_next    = BK_PRESS;
              scan_idx_next = '0;
            end
            OP_RELEASE: begin
              state_next    = BK_REL_SCAN;
              scan_idx_next = '0;
              start_rel     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      BK_PRESS: begin
        if (!used[scan_idx]) begin
          alloc      = 1'b1;
          out_push   = 1'b1;
          out_word   = '{start_time: cmd_q.time_stamp, end_time: cmd_q.time_stamp,
                         event_key: cmd_q.key, is_release: 1'b0, table_full: 1'b0};
          state_next = BK_IDLE;
        end else if (scan_idx == LAST_SLOT) begin
          out_push   = 1'b1;
          out_word   = '{start_time: cmd_q.time_stamp, end_time: cmd_q.time_stamp,
                         event_key: cmd_q.key, is_release: 1'b0, table_full: 1'b1};
          state_next = BK_IDLE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      BK_REL_SCAN: begin
        issue = 1'b1;
        if (scan_idx == LAST_SLOT) begin
          state_next = BK_REL_DRAIN;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      BK_REL_DRAIN: begin
        state_next = BK_REL_DONE;
      end
      BK_REL_DONE: begin
        if (found) begin
          commit   = 1'b1;
          out_push = 1'b1;
          out_word = '{start_time: best_start, end_time: cmd_q.time_stamp,
                       event_key: cmd_q.key, is_release: 1'b1, table_full: 1'b0};
        end
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      scan_idx  <= '0;
      cmp_vld   <= 1'b0;
      found     <= 1'b0;
      used      <= '0;
      committed <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      cmp_vld  <= issue;
      if (start_rel) begin
        found <= 1'b0;
      end else if (cmp_vld && hit && (!found || gap < best_dist)) begin
        found <= 1'b1;
      end
      if (clear_all) begin
        used      <= used & ~committed;
        committed <= '0;
      end
      if (alloc) begin
        used[scan_idx]      <= 1'b1;
        committed[scan_idx] <= 1'b0;
      end
      if (commit) begin
        committed[best_idx] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_q <= cmd;
    end
    cmp_idx <= scan_idx;
    if (cmp_vld && hit && (!found || gap < best_dist)) begin
      best_idx   <= cmp_idx;
      best_dist  <= gap;
      best_start <= start_rd;
    end
  end

  // slot memories: one write port each, registered read of key and start at the scan index
  always_ff @(posedge clk) begin
    if (alloc) begin
      key_mem[scan_idx]    <= cmd_q.key;
      start_mem[scan_idx]  <= cmd_q.time_stamp;
      detail_mem[scan_idx] <= {cmd_q.velocity, cmd_q.hand};
    end
    key_rd   <= key_mem[scan_idx];
    start_rd <= start_mem[scan_idx];
  end

  always_comb begin
    len_we   = alloc || commit;
    len_addr = alloc ? scan_idx : best_idx;
    len_data = alloc ? 32'd0 : (cmd_q.time_stamp - best_start);
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_addr] <= len_data;
    end
  end

  `ASSERT_NEVER(a_commit_free_slot, clk, rst, (committed & ~used) != '0)
  `ASSERT_PROP(a_push_has_room, clk, rst, out_push |-> out_space)
  `ASSERT_PROP(a_cmp_in_scan, clk, rst, cmp_vld |-> (state == BK_REL_SCAN || state == BK_REL_DRAIN))

endmodule

// ----- bench/midi_note_duration_tracker_tb.sv -----
`timescale 1ns / 1ps

module midi_note_duration_tracker_tb;
  import mndt_pkg::*;

  // word kind on the input side
  localparam logic KIND_MIDI  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // a release scans every slot; give the tail plenty of room
  localparam int DRAIN_CYCLES = 2 * NOTE_SLOTS + 40;
  localparam int CYCLE_LIMIT  = 1000000;

  // handshake pressure applied by driver and monitor
  typedef enum int {
    PH_FLOW,       // push and pop whenever possible
    PH_SEND_IDLE,  // sender idles with probability 63/100
    PH_RECV_STALL, // receiver stalls with probability 63/100
    PH_BOTH        // both sides idle with probability 16/100
  } pressure_t;

  typedef struct {
    logic        kind;
    logic [3:0]  status;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic [31:0] time_stamp;
    logic [1:0]  hand;
  } note_msg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        kind = KIND_MIDI;
  logic [3:0]  status = 4'h0;
  logic [6:0]  key = 7'h0;
  logic [6:0]  velocity = 7'h0;
  logic [31:0] time_stamp = 32'h0;
  logic [1:0]  hand = 2'h0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [6:0]  event_key;
  logic        is_release;
  logic        table_full;

  midi_note_duration_tracker DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .status     (status),
    .key        (key),
    .velocity   (velocity),
    .time_stamp (time_stamp),
    .hand       (hand),
    .empty      (empty),
    .pop        (pop),
    .start_time (start_time),
    .end_time   (end_time),
    .event_key  (event_key),
    .is_release (is_release),
    .table_full (table_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Note table as the bench sees it
  // ---------------------------------------------------------------------------
  logic        note_busy   [NOTE_SLOTS];
  logic        note_done   [NOTE_SLOTS];
  logic [6:0]  note_pitch  [NOTE_SLOTS];
  logic [31:0] note_onset  [NOTE_SLOTS];
  logic [6:0]  note_vel    [NOTE_SLOTS];
  logic [1:0]  note_hand   [NOTE_SLOTS];
  logic [31:0] note_length [NOTE_SLOTS];

  result_t     note_events[$];   // press/release events still owed by the block
  note_msg_t   msg_backlog[$];   // words waiting for the driver
  logic [6:0]  held_keys[$];     // keys pressed by the generator, not yet released
  pressure_t   pressure = PH_FLOW;
  logic [31:0] tick = 32'h0;     // generator's running clock of MIDI ticks
  int          words_queued = 0;
  int          bad_words = 0;
  int          cycle_count = 0;
  logic        word_taken = 1'b0;

  initial begin
    for (int i = 0; i < NOTE_SLOTS; i++) begin
      note_busy[i]   = 1'b0;
      note_done[i]   = 1'b0;
      note_pitch[i]  = 7'h0;
      note_onset[i]  = 32'h0;
      note_vel[i]    = 7'h0;
      note_hand[i]   = 2'h0;
      note_length[i] = 32'h0;
    end
  end

  // Apply one accepted word to the table and queue the event it causes.
  task automatic track_note(input note_msg_t m);
    int          pick;
    logic [31:0] gap;
    logic [31:0] best_gap;
    result_t     ev;
    pick = -1;
    best_gap = 32'h0;
    // clear: committed slots go back to the free pool, no event
    if (m.kind == KIND_CLEAR) begin
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        if (note_busy[i] && note_done[i]) begin
          note_busy[i] = 1'b0;
          note_done[i] = 1'b0;
        end
      end
      return;
    end
    if (m.status != ST_NOTE_ON && m.status != ST_NOTE_OFF) return;
    // press: lowest free slot; on a full table still report, flagged
    if (m.status == ST_NOTE_ON && m.velocity != 7'd0) begin
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        if (!note_busy[i]) begin
          pick = i;
          break;
        end
      end
      ev.start_time = m.time_stamp;
      ev.end_time   = m.time_stamp;
      ev.event_key  = m.key;
      ev.is_release = 1'b0;
      ev.table_full = (pick < 0);
      if (pick >= 0) begin
        note_busy[pick]   = 1'b1;
        note_done[pick]   = 1'b0;
        note_pitch[pick]  = m.key;
        note_onset[pick]  = m.time_stamp;
        note_vel[pick]    = m.velocity;
        note_hand[pick]   = m.hand;
        note_length[pick] = 32'h0;
      end
      note_events = {note_events, ev};
      return;
    end
    // release: same key, strictly earlier onset, nearest wins, lowest slot on tie;
    // committed slots stay candidates
    for (int i = 0; i < NOTE_SLOTS; i++) begin
      if (note_busy[i] && note_pitch[i] == m.key && note_onset[i] < m.time_stamp) begin
        gap = m.time_stamp - note_onset[i];
        if (pick < 0 || gap < best_gap) begin
          pick = i;
          best_gap = gap;
        end
      end
    end
    if (pick < 0) return;
    note_length[pick] = best_gap;
    note_done[pick]   = 1'b1;
    ev.start_time = note_onset[pick];
    ev.end_time   = m.time_stamp;
    ev.event_key  = m.key;
    ev.is_release = 1'b1;
    ev.table_full = 1'b0;
    note_events = {note_events, ev};
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new word at the falling edge, held until the block takes it
  // ---------------------------------------------------------------------------
  function automatic bit idle_roll(input pressure_t p, input bit recv_side);
    int pct;
    pct = 0;
    if (p == PH_BOTH) pct = 16;
    else if (p == PH_SEND_IDLE && !recv_side) pct = 63;
    else if (p == PH_RECV_STALL && recv_side) pct = 63;
    return $urandom_range(0, 99) < pct;
  endfunction

  always @(negedge clk) begin : drive_words
    note_msg_t nxt;
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || word_taken) begin
        if (msg_backlog.size() > 0 && !idle_roll(pressure, 1'b0)) begin
          nxt = msg_backlog.pop_front();
          push       <= 1'b1;
          kind       <= nxt.kind;
          status     <= nxt.status;
          key        <= nxt.key;
          velocity   <= nxt.velocity;
          time_stamp <= nxt.time_stamp;
          hand       <= nxt.hand;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= !idle_roll(pressure, 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: accepted input words feed the table, accepted results are checked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    note_msg_t got;
    result_t   want;
    word_taken <= !rst && push && !full;
    if (!rst && push && !full) begin
      got = '{kind, status, key, velocity, time_stamp, hand};
      track_note(got);
    end
    if (!rst && pop && !empty) begin
      if (note_events.size() == 0) begin
        $error("result word with no event pending: start %0d end %0d key %0d",
               start_time, end_time, event_key);
        bad_words++;
      end else begin
        want = note_events.pop_front();
        if (start_time !== want.start_time) begin
          $error("start_time: expected %0d, got %0d", want.start_time, start_time);
          bad_words++;
        end
        if (end_time !== want.end_time) begin
          $error("end_time: expected %0d, got %0d", want.end_time, end_time);
          bad_words++;
        end
        if (event_key !== want.event_key) begin
          $error("event_key: expected %0d, got %0d", want.event_key, event_key);
          bad_words++;
        end
        if (is_release !== want.is_release) begin
          $error("is_release: expected %0d, got %0d", want.is_release, is_release);
          bad_words++;
        end
        if (table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, table_full);
          bad_words++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_msg(input logic k, input logic [3:0] st, input logic [6:0] ky,
                         input logic [6:0] vel, input logic [31:0] ts,
                         input logic [1:0] hd);
    note_msg_t m;
    m = '{k, st, ky, vel, ts, hd};
    msg_backlog = {msg_backlog, m};
    words_queued++;
  endtask

  // clear with junk in every ignored field
  task automatic add_clear();
    add_msg(KIND_CLEAR, 4'($urandom), 7'($urandom), 7'($urandom), $urandom, 2'($urandom));
  endtask

  // note-off in either spelling: status 8 any velocity, or note-on at velocity 0
  task automatic add_release(input logic [6:0] ky, input logic [31:0] ts);
    if ($urandom_range(0, 1))
      add_msg(KIND_MIDI, ST_NOTE_OFF, ky, 7'($urandom), ts, 2'($urandom));
    else
      add_msg(KIND_MIDI, ST_NOTE_ON, ky, 7'd0, ts, 2'($urandom));
  endtask

  // stray words: foreign statuses, orphan releases, clears
  task automatic add_noise();
    logic [3:0] st;
    case ($urandom_range(0, 2))
      0: begin
        do st = 4'($urandom); while (st == ST_NOTE_ON || st == ST_NOTE_OFF);
        add_msg(KIND_MIDI, st, 7'($urandom), 7'($urandom), $urandom, 2'($urandom));
      end
      1: add_release(7'($urandom), $urandom);
      default: add_clear();
    endcase
  endtask

  // A phrase presses a handful of notes, then releases them in random order
  // with clears mixed in. A flood overfills the table before releasing.
  task automatic play_phrase(input bit flood);
    int         n;
    int         idx;
    logic [6:0] k;
    n = flood ? NOTE_SLOTS + 6 : $urandom_range(1, 8);
    // jump the clock only when nothing is held, so releases still match
    if (held_keys.size() == 0 && $urandom_range(0, 5) == 0) tick = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) add_noise();
      // a narrow key range makes same-key overlaps and ties common
      k = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(60, 63)) : 7'($urandom);
      tick += $urandom_range(0, 12);
      add_msg(KIND_MIDI, ST_NOTE_ON, k, 7'($urandom_range(1, 127)), tick, 2'($urandom));
      held_keys = {held_keys, k};
    end
    while (held_keys.size() > 0) begin
      // now and then leave notes hanging for a later phrase
      if (!flood && $urandom_range(0, 9) == 0) break;
      idx = $urandom_range(0, held_keys.size() - 1);
      k = held_keys[idx];
      held_keys.delete(idx);
      tick += $urandom_range(1, 40);
      add_release(k, tick);
      if ($urandom_range(0, 3) == 0) add_clear();
      if ($urandom_range(0, 9) == 0) add_noise();
    end
    if ($urandom_range(0, 1)) add_clear();
  endtask

  task automatic wait_backlog();
    while (msg_backlog.size() != 0 || push) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Timeout
  // ---------------------------------------------------------------------------
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int goal;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, equal-onset miss, committed slot reused,
    // largest gap, nearest-onset tie, foreign statuses, clear then reuse
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd0, 7'd1, 32'h0, 2'd0);
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd127, 7'd127, 32'hFFFF_FFFF, 2'd3);
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd0, 7'd0, 32'h0, 2'd0);          // same tick: no match
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd0, 7'd127, 32'd100, 2'd1);
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd0, 7'd0, 32'd200, 2'd2);         // hits committed slot
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd127, 7'd5, 32'hFFFF_FFFF, 2'd0); // same tick
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd127, 7'd5, 32'hFFFF_FFFE, 2'd0); // earlier
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd5, 7'd64, 32'h0, 2'd2);
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd5, 7'd0, 32'hFFFF_FFFF, 2'd3);  // widest gap
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd60, 7'd42, 32'd1000, 2'd1);
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd60, 7'd43, 32'd1000, 2'd2);
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd60, 7'd44, 32'd900, 2'd3);
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd60, 7'd0, 32'd1500, 2'd0);      // tie: lower slot
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd77, 7'd0, 32'd50, 2'd0);        // key never pressed
    add_msg(KIND_MIDI, 4'h0, 7'd60, 7'd127, 32'd2000, 2'd1);
    add_msg(KIND_MIDI, 4'h7, 7'd127, 7'd127, 32'hFFFF_FFFF, 2'd3);
    add_msg(KIND_MIDI, 4'hA, 7'd0, 7'd1, 32'd3000, 2'd0);
    add_msg(KIND_MIDI, 4'hF, 7'd60, 7'd0, 32'd3000, 2'd2);
    add_msg(KIND_CLEAR, ST_NOTE_ON, 7'd60, 7'd127, 32'hFFFF_FFFF, 2'd3); // fields ignored
    add_msg(KIND_MIDI, ST_NOTE_ON, 7'd1, 7'd99, 32'd10, 2'd1);          // reuses slot 0
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd60, 7'd0, 32'd2000, 2'd0);       // next nearest
    add_msg(KIND_MIDI, ST_NOTE_OFF, 7'd1, 7'd0, 32'd11, 2'd0);
    add_clear();
    wait_backlog();

    // random: each pressure setting twice; the first chunk overfills the table
    tick = 32'd5000;
    for (int round = 0; round < 2; round++) begin
      for (int p = PH_FLOW; p <= PH_BOTH; p++) begin
        pressure = pressure_t'(p);
        goal = words_queued + 25;
        if (round == 0 && p == PH_FLOW) play_phrase(1'b1);
        while (words_queued < goal) play_phrase(1'b0);
        wait_backlog();
      end
    end

    // tail: free-running pop, then room for any stray late word
    pressure = PH_FLOW;
    while (note_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
